// ===== hdl/serial_backup_memory_slave_core_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the serial backup memory slave
// Concurrent checks on the rising clock edge, silenced while reset is high.
// ----------------------------------------------------------------------------
`ifndef SERIAL_BACKUP_MEMORY_SLAVE_CORE_DEFINES_SVH
`define SERIAL_BACKUP_MEMORY_SLAVE_CORE_DEFINES_SVH

// same-cycle implication
`define SBM_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SBM_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/sbm_pkg.sv =====
// ----------------------------------------------------------------------------
// sbm_pkg
// Types and fixed constants shared by the backup memory slave modules.
// ----------------------------------------------------------------------------
package sbm_pkg;

  localparam int CMD_ADDR_W = 17;
  localparam int CFG_W      = 24;
  localparam int MASK_W     = 32;
  localparam int BYTE_W     = 8;
  localparam int LEN_W      = 17;
  localparam int IDX_W      = 5;

  localparam logic [1:0] ACT_BIT   = 2'd0;
  localparam logic [1:0] ACT_TICK  = 2'd1;
  localparam logic [1:0] ACT_LOAD  = 2'd2;
  localparam logic [1:0] ACT_FETCH = 2'd3;

  localparam logic [7:0]       SYNC_PATTERN = 8'hA8;
  localparam logic [7:0]       HUNT_START   = 8'hFF;
  localparam logic [CFG_W-1:0] IDLE_RESET   = 24'd750000;
  localparam logic [CFG_W-1:0] COUNT_MAX    = 24'hFFFFFF;

  // address field lands on address bits 7 upwards (128-byte units)
  localparam logic [IDX_W-1:0] ADDR_LSB_POS   = 5'd7;
  localparam logic [IDX_W-1:0] ADDR_FIELD_LEN = 5'd10;
  localparam logic [IDX_W-1:0] BITLEN_LEN     = 5'd3;
  localparam logic [IDX_W-1:0] BYTELEN_LEN    = 5'd17;
  localparam logic [IDX_W-1:0] BYTE_BITS      = 5'd8;
  localparam logic [IDX_W-1:0] TRAILW_LEN     = 5'd2;
  localparam logic [IDX_W-1:0] TRAIL_LEN      = 5'd3;

  typedef enum logic [3:0] {
    PH_HUNT, PH_ID1, PH_ID2, PH_CMD, PH_ADDR, PH_BITLEN, PH_BYTELEN,
    PH_BYTES, PH_PART, PH_TRAILW, PH_TRAIL
  } phase_t;

  typedef enum logic [2:0] {
    MOP_NONE, MOP_RD_BIT, MOP_WR_FIRST, MOP_WR_OR, MOP_WR_PUT, MOP_LOAD, MOP_FETCH
  } mem_op_t;

  typedef enum logic [1:0] {
    DOP_KEEP, DOP_MEM, DOP_ZERO
  } data_op_t;

  typedef struct packed {
    logic read;
    logic write;
    logic active;
    logic ident;
  } lines_t;

  // one accepted item on its way from the sequencer to the store stage
  typedef struct packed {
    mem_op_t           mop;
    data_op_t          dop;
    logic [2:0]        bit_idx;
    logic              bit_val;
    logic [BYTE_W-1:0] wdata;
    logic              end_sess;
    lines_t            lv;
    logic              flush;
    logic [MASK_W-1:0] mask;
  } sbm_op_t;

  typedef struct packed {
    logic              data_out;
    logic              ident_out;
    logic              active_out;
    logic              write_active;
    logic              read_active;
    logic              flush_valid;
    logic [MASK_W-1:0] dirty_mask;
    logic [BYTE_W-1:0] fetched_data;
  } sbm_res_t;

endpackage

// ===== hdl/sbm_if.sv =====
// ----------------------------------------------------------------------------
// sbm_cmd_if / sbm_res_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface sbm_cmd_if;
  import sbm_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [1:0]            action;
  logic                  rx_bit;
  logic [CMD_ADDR_W-1:0] mem_address;
  logic [BYTE_W-1:0]     mem_data;

  modport source (output valid, action, rx_bit, mem_address, mem_data, input ready);
  modport sink   (input valid, action, rx_bit, mem_address, mem_data, output ready);
endinterface

interface sbm_res_if;
  import sbm_pkg::*;
  logic              valid;
  logic              ready;
  logic              data_out;
  logic              ident_out;
  logic              active_out;
  logic              write_active;
  logic              read_active;
  logic              flush_valid;
  logic [MASK_W-1:0] dirty_mask;
  logic [BYTE_W-1:0] fetched_data;

  modport source (output valid, data_out, ident_out, active_out, write_active,
                  read_active, flush_valid, dirty_mask, fetched_data, input ready);
  modport sink   (input valid, data_out, ident_out, active_out, write_active,
                  read_active, flush_valid, dirty_mask, fetched_data, output ready);
endinterface

// ===== hdl/serial_backup_memory_slave_core.sv =====
// ----------------------------------------------------------------------------
// serial_backup_memory_slave_core
// Serial slave for a backup memory with dirty-page tracking and idle flush.
//
//   channel  dir  handshake          content
//   cmd      in   valid/ready        action, rx_bit, mem_address, mem_data
//   res      out  valid/ready        line levels, flush report, fetched byte
//   cfg      in   cfg_wr_en only     idle_ticks (24 bits)
//
// One item per cycle while the result channel keeps up; the memory is read on the accepting
// edge, and the read-modify-write lands the result in the output register once that register
// is free, where the sink can take it. One read and one write port set the rate.
// Reset is synchronous; no clearing pass, memory contents are undefined until
// written. A stalled result holds in the output register while one more item enters
// the memory stage; the input then waits.
// ----------------------------------------------------------------------------
module serial_backup_memory_slave_core #(
  parameter int MEM_BYTES  = 131072,
  parameter int PAGE_BYTES = 4096
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  logic [sbm_pkg::CFG_W-1:0] cfg_wr_data,
  sbm_cmd_if.sink                   cmd,
  sbm_res_if.source                 res
);
  import sbm_pkg::*;

  localparam int AW = $clog2(MEM_BYTES);

  sbm_op_t       a_op;
  logic [AW-1:0] a_addr;
  sbm_res_t      b_res, out_r;
  logic          a_go, b_go, p_valid, out_v, out_free;

  // output register frees when empty or taken this cycle
  assign out_free  = !out_v || res.ready;
  // advance the memory stage into the output register
  assign b_go      = p_valid && out_free;
  // take a new item whenever the memory stage will be free
  assign cmd.ready = !p_valid || out_free;
  assign a_go      = cmd.valid && cmd.ready;

  sbm_ctrl #(
    .MEM_BYTES  (MEM_BYTES),
    .PAGE_BYTES (PAGE_BYTES)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .a_go        (a_go),
    .action      (cmd.action),
    .rx_bit      (cmd.rx_bit),
    .mem_address (cmd.mem_address),
    .mem_data    (cmd.mem_data),
    .op          (a_op),
    .op_addr     (a_addr)
  );

  sbm_store #(
    .MEM_BYTES (MEM_BYTES)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .a_go    (a_go),
    .a_op    (a_op),
    .a_addr  (a_addr),
    .b_go    (b_go),
    .p_valid (p_valid),
    .res     (b_res)
  );

  // hold the result until the sink takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (b_go) begin
      out_v <= 1'b1;
    end else if (res.ready) begin
      out_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_go) out_r <= b_res;
  end

  assign res.valid        = out_v;
  assign res.data_out     = out_r.data_out;
  assign res.ident_out    = out_r.ident_out;
  assign res.active_out   = out_r.active_out;
  assign res.write_active = out_r.write_active;
  assign res.read_active  = out_r.read_active;
  assign res.flush_valid  = out_r.flush_valid;
  assign res.dirty_mask   = out_r.dirty_mask;
  assign res.fetched_data = out_r.fetched_data;

endmodule

// ===== hdl/sbm_ctrl.sv =====
// ----------------------------------------------------------------------------
// sbm_ctrl
// Protocol sequencer: phase, counters, dirty pages and idle timer; issues
// one memory operation per accepted item.
// ----------------------------------------------------------------------------
`include "serial_backup_memory_slave_core_defines.svh"

module sbm_ctrl #(
  parameter int MEM_BYTES  = 131072,
  parameter int PAGE_BYTES = 4096
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [sbm_pkg::CFG_W-1:0]     cfg_wr_data,
  input  logic                          a_go,
  input  logic [1:0]                    action,
  input  logic                          rx_bit,
  input  logic [sbm_pkg::CMD_ADDR_W-1:0] mem_address,
  input  logic [sbm_pkg::BYTE_W-1:0]    mem_data,
  output sbm_pkg::sbm_op_t              op,
  output logic [$clog2(MEM_BYTES)-1:0]  op_addr
);
  import sbm_pkg::*;

  localparam int AW = $clog2(MEM_BYTES);
  localparam int PW = $clog2(PAGE_BYTES);

  phase_t            phase, phase_next;
  logic [7:0]        sync_shift, sync_next;
  logic [IDX_W-1:0]  fbi, fbi_next, fbi_inc;
  logic              is_read, is_read_next;
  logic [AW-1:0]     cur_address, cur_next, addr_bit, page_sel;
  logic [LEN_W-1:0]  bytes_left, bytes_next, bytes_dec, bytes_len_new;
  logic [2:0]        bits_left, bits_next, bits_dec, bit_k;
  logic [CFG_W-1:0]  idle_count, idle_next, idle_inc, idle_ticks;
  logic [MASK_W-1:0] dirty, dirty_next, page_bit;
  lines_t            lv, lv_next;
  logic              bit_go, ended;
  phase_t            trail_ph;

  assign bit_go        = a_go && (action == ACT_BIT);
  assign fbi_inc       = fbi + 5'd1;
  assign bit_k         = fbi[2:0];
  assign bytes_dec     = bytes_left - 17'd1;
  assign bits_dec      = bits_left - 3'd1;
  assign bytes_len_new = bytes_left | (LEN_W'(rx_bit) << fbi);
  assign addr_bit      = AW'(1) << (fbi + ADDR_LSB_POS);
  assign page_sel      = cur_address >> PW;
  assign page_bit      = MASK_W'(1) << page_sel[4:0];
  assign idle_inc      = (idle_count == COUNT_MAX) ? idle_count : idle_count + 24'd1;
  assign trail_ph      = is_read ? PH_TRAIL : PH_TRAILW;

  // next phase
  always_comb begin
    phase_next = phase;
    if (bit_go) begin
      case (phase)
        PH_HUNT:    if ({rx_bit, sync_shift[7:1]} == SYNC_PATTERN) phase_next = PH_ID1;
        PH_ID1:     phase_next = PH_ID2;
        PH_ID2:     phase_next = PH_CMD;
        PH_CMD:     phase_next = PH_ADDR;
        PH_ADDR:    if (fbi_inc >= ADDR_FIELD_LEN) phase_next = PH_BITLEN;
        PH_BITLEN:  if (fbi_inc >= BITLEN_LEN) phase_next = PH_BYTELEN;
        PH_BYTELEN: begin
          if (fbi_inc >= BYTELEN_LEN) begin
            if (bytes_len_new != '0)   phase_next = PH_BYTES;
            else if (bits_left != '0) phase_next = PH_PART;
            else                       phase_next = trail_ph;
          end
        end
        PH_BYTES: begin
          if (fbi_inc >= BYTE_BITS && bytes_dec == '0) begin
            phase_next = (bits_left != '0) ? PH_PART : trail_ph;
          end
        end
        PH_PART:    if (bits_dec == '0 || fbi_inc >= BYTE_BITS) phase_next = trail_ph;
        PH_TRAILW:  if (fbi_inc >= TRAILW_LEN) phase_next = PH_TRAIL;
        PH_TRAIL:   if (fbi_inc >= TRAIL_LEN) phase_next = PH_HUNT;
        default:    phase_next = PH_HUNT;
      endcase
    end
  end

  // register updates and the operation handed to the store stage
  always_comb begin
    sync_next    = sync_shift;
    fbi_next     = fbi;
    is_read_next = is_read;
    cur_next     = cur_address;
    bytes_next   = bytes_left;
    bits_next    = bits_left;
    idle_next    = idle_count;
    dirty_next   = dirty;
    lv_next      = lv;
    ended        = 1'b0;
    op_addr      = cur_address;
    op.mop       = MOP_NONE;
    op.dop       = DOP_KEEP;
    op.bit_idx   = bit_k;
    op.bit_val   = rx_bit;
    op.wdata     = mem_data;
    op.end_sess  = 1'b0;
    op.flush     = 1'b0;
    op.mask      = '0;
    if (a_go) begin
      case (action)
        ACT_BIT: begin
          case (phase)
            PH_HUNT: begin
              sync_next = {rx_bit, sync_shift[7:1]};
              if (sync_next == SYNC_PATTERN) lv_next.active = 1'b1;
            end
            PH_ID1, PH_ID2: lv_next.ident = rx_bit;
            PH_CMD: begin
              is_read_next  = rx_bit;
              lv_next.ident = 1'b0;
              if (rx_bit) lv_next.read = 1'b1;
              else        lv_next.write = 1'b1;
              cur_next = '0;
              fbi_next = '0;
            end
            PH_ADDR: begin
              if (rx_bit) cur_next = cur_address | addr_bit;
              fbi_next = fbi_inc;
              if (fbi_inc >= ADDR_FIELD_LEN) begin
                fbi_next  = '0;
                bits_next = '0;
              end
            end
            PH_BITLEN: begin
              bits_next = bits_left | (3'(rx_bit) << fbi[1:0]);
              fbi_next  = fbi_inc;
              if (fbi_inc >= BITLEN_LEN) begin
                fbi_next   = '0;
                bytes_next = '0;
              end
            end
            PH_BYTELEN: begin
              bytes_next = bytes_len_new;
              fbi_next   = (fbi_inc >= BYTELEN_LEN) ? '0 : fbi_inc;
            end
            PH_BYTES: begin
              if (is_read) begin
                op.mop = MOP_RD_BIT;
                op.dop = DOP_MEM;
              end else if (bit_k == 3'd0) begin
                op.mop     = MOP_WR_FIRST;
                dirty_next = dirty | page_bit;
              end else begin
                op.mop = MOP_WR_OR;
              end
              fbi_next = fbi_inc;
              if (fbi_inc >= BYTE_BITS) begin
                cur_next   = cur_address + AW'(1);
                bytes_next = bytes_dec;
                fbi_next   = '0;
              end
            end
            PH_PART: begin
              if (is_read) begin
                op.mop = MOP_RD_BIT;
                op.dop = DOP_MEM;
              end else begin
                op.mop = MOP_WR_PUT;
                if (bit_k == 3'd0) dirty_next = dirty | page_bit;
              end
              bits_next = bits_dec;
              fbi_next  = (bits_dec == '0 || fbi_inc >= BYTE_BITS) ? '0 : fbi_inc;
            end
            PH_TRAILW: begin
              if (bit_k == 3'd0) op.dop = DOP_ZERO;
              fbi_next = (fbi_inc >= TRAILW_LEN) ? '0 : fbi_inc;
            end
            PH_TRAIL: begin
              if (bit_k == 3'd0) op.dop = DOP_ZERO;
              fbi_next = fbi_inc;
              if (fbi_inc >= TRAIL_LEN) begin
                if (dirty != '0) idle_next = '0;
                ended = 1'b1;
              end
            end
            default: begin
              lv_next = '0;
              op.dop  = DOP_ZERO;
              ended   = 1'b1;
            end
          endcase
        end
        ACT_TICK: begin
          if (dirty != '0) begin
            idle_next = idle_inc;
            if (phase == PH_HUNT && idle_inc > idle_ticks) begin
              op.flush   = 1'b1;
              op.mask    = dirty;
              dirty_next = '0;
              idle_next  = '0;
            end
          end
        end
        ACT_LOAD: begin
          op.mop  = MOP_LOAD;
          op_addr = mem_address[AW-1:0];
        end
        ACT_FETCH: begin
          op.mop  = MOP_FETCH;
          op_addr = mem_address[AW-1:0];
        end
        default: ;
      endcase
    end
    op.lv       = lv_next;
    op.end_sess = ended;
    if (ended) begin
      lv_next   = '0;
      sync_next = HUNT_START;
      fbi_next  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HUNT;
      sync_shift <= HUNT_START;
      fbi        <= '0;
      is_read    <= 1'b0;
      cur_address <= '0;
      bytes_left <= '0;
      bits_left  <= '0;
      idle_count <= '0;
      dirty      <= '0;
      lv         <= '0;
      idle_ticks <= IDLE_RESET;
    end else begin
      phase      <= phase_next;
      sync_shift <= sync_next;
      fbi        <= fbi_next;
      is_read    <= is_read_next;
      cur_address <= cur_next;
      bytes_left <= bytes_next;
      bits_left  <= bits_next;
      idle_count <= idle_next;
      dirty      <= dirty_next;
      lv         <= lv_next;
      if (cfg_wr_en) idle_ticks <= cfg_wr_data;
    end
  end

  `SBM_ASSERT_IMP(a_active_in_session, clk, rst, phase != PH_HUNT, lv.active, "session without active line")
  `SBM_ASSERT_IMP(a_flush_has_pages, clk, rst, op.flush, dirty != '0, "flush with empty mask")
  `SBM_ASSERT_NXT(a_flush_clears, clk, rst, op.flush, dirty == '0, "dirty pages kept after flush")
  `SBM_ASSERT_NXT(a_hunt_holds, clk, rst, phase == PH_HUNT && !bit_go, $stable(sync_shift), "sync shifted without a bit")

endmodule

// ===== hdl/sbm_store.sv =====
// ----------------------------------------------------------------------------
// sbm_store
// Backup memory with registered read, read-modify-write stage and forwarding
// of the most recent write; drives the data line level.
// ----------------------------------------------------------------------------
module sbm_store #(
  parameter int MEM_BYTES = 131072
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         a_go,
  input  sbm_pkg::sbm_op_t             a_op,
  input  logic [$clog2(MEM_BYTES)-1:0] a_addr,
  input  logic                         b_go,
  output logic                         p_valid,
  output sbm_pkg::sbm_res_t            res
);
  import sbm_pkg::*;

  localparam int AW = $clog2(MEM_BYTES);

  logic [BYTE_W-1:0] mem [MEM_BYTES];
  logic [BYTE_W-1:0] rdata, rbyte, wbyte, bit_mask;
  sbm_op_t           p_op;
  logic [AW-1:0]     p_addr, lw_addr;
  logic [BYTE_W-1:0] lw_data;
  logic              lw_valid, mem_we, data_lvl, data_shown;

  // write at the store stage, read for the item being accepted (old data)
  always_ff @(posedge clk) begin
    if (mem_we) mem[p_addr] <= wbyte;
    if (a_go) rdata <= mem[a_addr];
  end

  // a write on the same edge as the read is not seen by it: forward it
  assign rbyte    = (lw_valid && lw_addr == p_addr) ? lw_data : rdata;
  assign bit_mask = BYTE_W'(1) << p_op.bit_idx;

  always_comb begin
    case (p_op.mop)
      MOP_WR_FIRST: wbyte = BYTE_W'(p_op.bit_val);
      MOP_WR_OR:    wbyte = rbyte | (BYTE_W'(p_op.bit_val) << p_op.bit_idx);
      MOP_WR_PUT:   wbyte = (rbyte & ~bit_mask) | (BYTE_W'(p_op.bit_val) << p_op.bit_idx);
      MOP_LOAD:     wbyte = p_op.wdata;
      default:      wbyte = rbyte;
    endcase
    mem_we = b_go && (p_op.mop inside {MOP_WR_FIRST, MOP_WR_OR, MOP_WR_PUT, MOP_LOAD});
  end

  always_comb begin
    case (p_op.dop)
      DOP_MEM:  data_shown = rbyte[p_op.bit_idx];
      DOP_ZERO: data_shown = 1'b0;
      default:  data_shown = data_lvl;
    endcase
    res.data_out     = data_shown;
    res.ident_out    = p_op.lv.ident;
    res.active_out   = p_op.lv.active;
    res.write_active = p_op.lv.write;
    res.read_active  = p_op.lv.read;
    res.flush_valid  = p_op.flush;
    res.dirty_mask   = p_op.mask;
    res.fetched_data = (p_op.mop == MOP_FETCH) ? rbyte : '0;
  end

  always_ff @(posedge clk) begin
    if (a_go) begin
      p_op   <= a_op;
      p_addr <= a_addr;
    end
    if (mem_we) begin
      lw_addr <= p_addr;
      lw_data <= wbyte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid  <= 1'b0;
      lw_valid <= 1'b0;
      data_lvl <= 1'b0;
    end else begin
      if (a_go)      p_valid <= 1'b1;
      else if (b_go) p_valid <= 1'b0;
      if (mem_we)    lw_valid <= 1'b1;
      if (b_go)      data_lvl <= p_op.end_sess ? 1'b0 : data_shown;
    end
  end

endmodule

// ===== test/sbm_response_checker.sv =====
// ----------------------------------------------------------------------------
// sbm_response_checker
// Watches the item and result channels and the idle limit port, keeps its own
// copy of the slave state, and compares each result item with the oldest
// predicted one. The mismatch count and the number of results still owed are
// handed to the test top.
// ----------------------------------------------------------------------------
module sbm_response_checker
  import sbm_pkg::*;
#(
  parameter int MEM_BYTES  = 131072,
  parameter int PAGE_BYTES = 4096
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [CFG_W-1:0] cfg_wr_data,
  sbm_cmd_if               cmd,
  sbm_res_if               res,
  output int               fail_count,
  output int               pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // shadow of the slave
  logic [BYTE_W-1:0] backup_copy [MEM_BYTES];
  logic [MASK_W-1:0] dirty;
  logic [7:0]        hunt_reg;
  phase_t            phase;
  logic [IDX_W-1:0]  fidx;
  logic              rd_sess;
  logic [LEN_W-1:0]  addr_reg;
  logic [LEN_W-1:0]  bytes_left;
  logic [2:0]        bits_left;
  logic [CFG_W-1:0]  idle_cnt;
  logic [CFG_W-1:0]  idle_lim;
  lines_t            lv;
  logic              data_lv;

  sbm_res_t awaited_results [$];
  int       n_seen;
  int       fail_cnt;

  assign fail_count = fail_cnt;

  initial begin
    fail_cnt = 0;
    n_seen   = 0;
  end

  function automatic void go_hunt();
    phase    = PH_HUNT;
    hunt_reg = HUNT_START;
    fidx     = '0;
    lv       = '0;
    data_lv  = 1'b0;
  endfunction

  function automatic void mark_page();
    dirty[(int'(addr_reg) / PAGE_BYTES) % 32] = 1'b1;
  endfunction

  function automatic void begin_trailer();
    fidx  = '0;
    phase = rd_sess ? PH_TRAIL : PH_TRAILW;
  endfunction

  function automatic void counts_done();
    fidx = '0;
    if (bytes_left != 0) phase = PH_BYTES;
    else if (bits_left != 0) phase = PH_PART;
    else begin_trailer();
  endfunction

  // advance the protocol by one serial bit; high when the session ends here
  function automatic logic take_serial_bit(logic b);
    int k;
    int a;
    k = int'(fidx);
    a = int'(addr_reg) % MEM_BYTES;
    case (phase)
      PH_HUNT: begin
        hunt_reg = {b, hunt_reg[7:1]};
        if (hunt_reg == SYNC_PATTERN) begin
          lv.active = 1'b1;
          phase = PH_ID1;
        end
      end
      PH_ID1, PH_ID2: begin
        lv.ident = b;
        phase = (phase == PH_ID1) ? PH_ID2 : PH_CMD;
      end
      PH_CMD: begin
        rd_sess  = b;
        lv.ident = 1'b0;
        if (b) lv.read = 1'b1;
        else lv.write = 1'b1;
        addr_reg = '0;
        fidx     = '0;
        phase    = PH_ADDR;
      end
      PH_ADDR: begin
        if (b) addr_reg[int'(ADDR_LSB_POS) + k] = 1'b1;
        fidx++;
        if (fidx >= ADDR_FIELD_LEN) begin
          addr_reg  = LEN_W'(int'(addr_reg) % MEM_BYTES);
          fidx      = '0;
          bits_left = '0;
          phase     = PH_BITLEN;
        end
      end
      PH_BITLEN: begin
        bits_left[k] = b;
        fidx++;
        if (fidx >= BITLEN_LEN) begin
          fidx       = '0;
          bytes_left = '0;
          phase      = PH_BYTELEN;
        end
      end
      PH_BYTELEN: begin
        bytes_left[k] = b;
        fidx++;
        if (fidx >= BYTELEN_LEN) counts_done();
      end
      PH_BYTES: begin
        k = k % 8;
        if (rd_sess) data_lv = backup_copy[a][k];
        else if (k == 0) begin
          mark_page();
          backup_copy[a] = BYTE_W'(b);
        end else backup_copy[a] = backup_copy[a] | (BYTE_W'(b) << k);
        fidx++;
        if (fidx >= BYTE_BITS) begin
          addr_reg   = LEN_W'((a + 1) % MEM_BYTES);
          bytes_left = bytes_left - 1'b1;
          if (bytes_left == 0) counts_done();
          else fidx = '0;
        end
      end
      PH_PART: begin
        k = k % 8;
        if (rd_sess) data_lv = backup_copy[a][k];
        else begin
          if (k == 0) mark_page();
          backup_copy[a][k] = b;
        end
        fidx++;
        bits_left = bits_left - 1'b1;
        if (bits_left == 0 || fidx >= BYTE_BITS) begin_trailer();
      end
      PH_TRAILW: begin
        if (k == 0) data_lv = 1'b0;
        fidx++;
        if (fidx >= TRAILW_LEN) begin
          fidx  = '0;
          phase = PH_TRAIL;
        end
      end
      PH_TRAIL: begin
        if (k == 0) data_lv = 1'b0;
        fidx++;
        if (fidx >= TRAIL_LEN) begin
          if (dirty != 0) idle_cnt = '0;
          return 1'b1;
        end
      end
      default: go_hunt();
    endcase
    return 1'b0;
  endfunction

  // work out the result item that one input item causes
  function automatic sbm_res_t next_response(logic [1:0] act, logic rx,
                                             logic [CMD_ADDR_W-1:0] ma,
                                             logic [BYTE_W-1:0] md);
    sbm_res_t r;
    logic     ended;
    int       a;
    r     = '0;
    ended = 1'b0;
    a     = int'(ma) % MEM_BYTES;
    case (act)
      ACT_BIT: ended = take_serial_bit(rx);
      ACT_TICK: begin
        if (dirty != 0) begin
          if (idle_cnt != COUNT_MAX) idle_cnt++;
          if (phase == PH_HUNT && idle_cnt > idle_lim) begin
            r.flush_valid = 1'b1;
            r.dirty_mask  = dirty;
            dirty         = '0;
            idle_cnt      = '0;
          end
        end
      end
      ACT_LOAD: backup_copy[a] = md;
      ACT_FETCH: r.fetched_data = backup_copy[a];
      default: ;
    endcase
    r.data_out     = data_lv;
    r.ident_out    = lv.ident;
    r.active_out   = lv.active;
    r.write_active = lv.write;
    r.read_active  = lv.read;
    if (ended) go_hunt();
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [MASK_W-1:0] got,
                                 logic [MASK_W-1:0] want);
    fail_cnt++;
    if (fail_cnt <= 40)
      $display("%0t ns: result %0d: %s is %0h, predicted %0h", $time, n_seen, what, got, want);
  endtask

  always @(posedge clk) begin
    sbm_res_t want;
    if (rst) begin
      dirty      = '0;
      rd_sess    = 1'b0;
      addr_reg   = '0;
      bytes_left = '0;
      bits_left  = '0;
      idle_cnt   = '0;
      idle_lim   = IDLE_RESET;
      go_hunt();
      awaited_results.delete();
    end else begin
      if (cfg_wr_en) idle_lim = cfg_wr_data;
      // retire before predicting: a result never belongs to an item of this edge
      if (res.valid && res.ready) begin
        if (awaited_results.size() == 0) begin
          report_mismatch("unexpected result item", 1, 0);
        end else begin
          want = awaited_results.pop_front();
          if (res.data_out !== want.data_out)
            report_mismatch("data_out", res.data_out, want.data_out);
          if (res.ident_out !== want.ident_out)
            report_mismatch("ident_out", res.ident_out, want.ident_out);
          if (res.active_out !== want.active_out)
            report_mismatch("active_out", res.active_out, want.active_out);
          if (res.write_active !== want.write_active)
            report_mismatch("write_active", res.write_active, want.write_active);
          if (res.read_active !== want.read_active)
            report_mismatch("read_active", res.read_active, want.read_active);
          if (res.flush_valid !== want.flush_valid)
            report_mismatch("flush_valid", res.flush_valid, want.flush_valid);
          if (res.dirty_mask !== want.dirty_mask)
            report_mismatch("dirty_mask", res.dirty_mask, want.dirty_mask);
          if (res.fetched_data !== want.fetched_data)
            report_mismatch("fetched_data", res.fetched_data, want.fetched_data);
        end
        n_seen++;
      end
      if (cmd.valid && cmd.ready)
        awaited_results.push_back(next_response(cmd.action, cmd.rx_bit,
                                                cmd.mem_address, cmd.mem_data));
    end
    pending <= awaited_results.size();
  end

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Regression for the serial backup memory slave. Drives protocol bits, time
// ticks, loads and fetches into the item channel with random gaps, stalls the
// result channel at random, and steps the idle limit through several values.
// The checker beside the block predicts and compares every result item.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sbm_pkg::*;

  localparam int MEM_BYTES = 131072;

  logic             clk = 1'b0;
  logic             rst;
  logic             cfg_wr_en;
  logic [CFG_W-1:0] cfg_wr_data;
  int               n_fail;
  int               n_pending;

  sbm_cmd_if cmd_ch ();
  sbm_res_if res_ch ();

  serial_backup_memory_slave_core uut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd_ch),
    .res         (res_ch)
  );

  sbm_response_checker chk (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd_ch),
    .res         (res_ch),
    .fail_count  (n_fail),
    .pending     (n_pending)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // hunt register as the block should hold it while no session runs;
  // lets the stimulus keep stray bits from forming the sync byte
  logic [7:0] sync_track = HUNT_START;

  // bytes with a defined value: only these may ever be read back
  bit known_byte [int];
  int known_list [$];

  int calm_cmd   = 0;
  int n_items    = 0;
  int n_ticks    = 0;
  int n_sessions = 0;
  int n_reads    = 0;
  int n_limits   = 0;

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(13, 40);
  endfunction

  // offer one item after a random gap and hold it until it is taken
  task automatic put_item(logic [1:0] act, logic rx, logic [CMD_ADDR_W-1:0] ma,
                          logic [BYTE_W-1:0] md);
    int gap;
    if (calm_cmd > 0) begin
      calm_cmd--;
      gap = 0;
    end else begin
      gap = gap_len();
      // now and then a stretch of back-to-back items
      if ($urandom_range(0, 59) == 0) calm_cmd = $urandom_range(20, 80);
    end
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_ch.valid       <= 1'b1;
    cmd_ch.action      <= act;
    cmd_ch.rx_bit      <= rx;
    cmd_ch.mem_address <= ma;
    cmd_ch.mem_data    <= md;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    n_items++;
    if (act == ACT_TICK) n_ticks++;
  endtask

  // the address and data fields are don't-care on bits and ticks: fill with noise
  task automatic send_bit(logic b);
    put_item(ACT_BIT, b, CMD_ADDR_W'($urandom_range(0, MEM_BYTES - 1)),
             BYTE_W'($urandom_range(0, 255)));
  endtask

  task automatic send_tick();
    put_item(ACT_TICK, 1'($urandom_range(0, 1)),
             CMD_ADDR_W'($urandom_range(0, MEM_BYTES - 1)), BYTE_W'($urandom_range(0, 255)));
  endtask

  function automatic void mark_known(int a);
    if (!known_byte.exists(a)) begin
      known_byte[a] = 1'b1;
      known_list.push_back(a);
    end
  endfunction

  task automatic fetch_byte(int a);
    put_item(ACT_FETCH, 1'($urandom_range(0, 1)), CMD_ADDR_W'(a),
             BYTE_W'($urandom_range(0, 255)));
  endtask

  task automatic load_byte(int a, logic [BYTE_W-1:0] d);
    put_item(ACT_LOAD, 1'($urandom_range(0, 1)), CMD_ADDR_W'(a), d);
    mark_known(a);
  endtask

  task automatic ensure_known(int a);
    if (!known_byte.exists(a)) load_byte(a, BYTE_W'($urandom_range(0, 255)));
  endtask

  // a stray bit while hunting: flip it if it would complete the sync byte
  task automatic noise_bit(logic b);
    if ({b, sync_track[7:1]} == SYNC_PATTERN) b = ~b;
    sync_track = {b, sync_track[7:1]};
    send_bit(b);
  endtask

  // the first k bits of the sync pattern, then the wrong one
  task automatic near_miss(int k);
    int i;
    for (i = 0; i < k; i++) noise_bit(SYNC_PATTERN[i]);
    noise_bit(~SYNC_PATTERN[k]);
  endtask

  // a tick, a load anywhere, or a fetch of a byte already defined
  task automatic side_item();
    case ($urandom_range(0, 2))
      0: send_tick();
      1: load_byte($urandom_range(0, MEM_BYTES - 1), BYTE_W'($urandom_range(0, 255)));
      default: begin
        if (known_list.size() > 0)
          fetch_byte(known_list[$urandom_range(0, known_list.size() - 1)]);
        else send_tick();
      end
    endcase
  endtask

  // hold off new items until every result is back
  task automatic drain();
    cmd_ch.valid <= 1'b0;
    @(posedge clk);
    while (n_pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // new idle limit: written only with the block idle
  task automatic set_limit(logic [CFG_W-1:0] v);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    n_limits++;
  endtask

  // one complete session: sync, ident, command, address, counts, data, trailer
  task automatic run_session(logic rd, logic [9:0] seg, logic [2:0] nbits,
                             logic [LEN_W-1:0] nbytes);
    logic stream [$];
    int   base_a;
    int   i;
    base_a = int'(seg) * 128;
    // a read, or a partial write, touches bytes that must already be defined
    if (rd) begin
      for (i = 0; i < int'(nbytes) + (nbits != 0 ? 1 : 0); i++)
        ensure_known((base_a + i) % MEM_BYTES);
    end else if (nbits != 0) ensure_known((base_a + int'(nbytes)) % MEM_BYTES);
    repeat ($urandom_range(0, 3)) noise_bit(1'b1);
    // stop early should the line history already complete the sync byte
    for (i = 0; i < 8; i++) begin
      sync_track = {SYNC_PATTERN[i], sync_track[7:1]};
      send_bit(SYNC_PATTERN[i]);
      if (sync_track == SYNC_PATTERN) break;
    end
    stream.push_back(1'($urandom_range(0, 1)));
    stream.push_back(1'($urandom_range(0, 1)));
    stream.push_back(rd);
    for (i = 0; i < 10; i++) stream.push_back(seg[i]);
    for (i = 0; i < 3; i++) stream.push_back(nbits[i]);
    for (i = 0; i < LEN_W; i++) stream.push_back(nbytes[i]);
    // data bits, then the trailer (two more on a write)
    for (i = 0; i < int'(nbytes) * 8 + int'(nbits) + (rd ? 3 : 5); i++)
      stream.push_back(1'($urandom_range(0, 1)));
    foreach (stream[j]) begin
      if ($urandom_range(0, 24) == 0) side_item();
      send_bit(stream[j]);
    end
    if (!rd)
      for (i = 0; i < int'(nbytes); i++) mark_known((base_a + i) % MEM_BYTES);
    sync_track = HUNT_START;
    n_sessions++;
    if (rd) n_reads++;
  endtask

  // result side: ready mostly high, random stalls, some long open stretches
  initial begin
    int hold;
    int stall;
    res_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      res_ch.ready <= 1'b1;
      hold = $urandom_range(1, 6);
      if ($urandom_range(0, 49) == 0) hold = $urandom_range(30, 120);
      repeat (hold) @(posedge clk);
      stall = gap_len();
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  // stimulus and verdict
  initial begin
    int r;
    int nb;
    logic [CFG_W-1:0] lim;
    rst                <= 1'b1;
    cfg_wr_en          <= 1'b0;
    cfg_wr_data        <= '0;
    cmd_ch.valid       <= 1'b0;
    cmd_ch.action      <= ACT_TICK;
    cmd_ch.rx_bit      <= 1'b0;
    cmd_ch.mem_address <= '0;
    cmd_ch.mem_data    <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // --- directed part ---
    // loads and fetches at the address and data extremes
    load_byte(0, 8'h00);
    load_byte(MEM_BYTES - 1, 8'hFF);
    load_byte('h15555, 8'hA5);
    load_byte('h0AAAA, 8'h5A);
    fetch_byte(MEM_BYTES - 1);
    fetch_byte(0);
    fetch_byte('h15555);
    fetch_byte('h0AAAA);
    // ticks with nothing dirty do nothing
    send_tick();
    send_tick();
    // a sync pattern broken one bit short
    near_miss(7);
    // write one whole byte and a partial one, then read them back
    run_session(1'b0, 10'd0, 3'd3, 17'd1);
    repeat (3) send_tick();
    run_session(1'b1, 10'd0, 3'd2, 17'd1);
    // zero limit: the next tick while hunting reports page 0
    set_limit('0);
    send_tick();
    // an empty session goes straight to its trailer
    run_session(1'b0, 10'd5, 3'd0, 17'd0);
    send_tick();
    // write in the top segment of memory: page 31, two bytes and a partial one
    run_session(1'b0, 10'h3FF, 3'd4, 17'd2);
    send_tick();
    fetch_byte(MEM_BYTES - 1);
    fetch_byte(0);
    // partial byte only, longest bit count
    run_session(1'b1, 10'h3FF, 3'd7, 17'd0);
    // saturating limit: never reports
    set_limit(COUNT_MAX);
    run_session(1'b0, 10'd512, 3'd0, 17'd1);
    repeat (4) send_tick();
    set_limit(24'd3);
    repeat (5) send_tick();

    // --- random part ---
    while (n_items < 450) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        nb = $urandom_range(0, 99);
        if (nb < 60) nb = $urandom_range(0, 2);
        else if (nb < 92) nb = $urandom_range(3, 6);
        else nb = $urandom_range(7, 16);
        run_session(1'($urandom_range(0, 1)),
                    ($urandom_range(0, 9) == 0) ? 10'h3FF : 10'($urandom_range(0, 1023)),
                    3'($urandom_range(0, 7)), LEN_W'(nb));
      end else if (r < 70) begin
        repeat ($urandom_range(1, 12)) send_tick();
      end else if (r < 80) begin
        repeat ($urandom_range(1, 4)) side_item();
      end else if (r < 88) begin
        repeat ($urandom_range(1, 12)) noise_bit(1'($urandom_range(0, 1)));
      end else if (r < 93) begin
        near_miss($urandom_range(0, 7));
      end else if (r < 97) begin
        case ($urandom_range(0, 4))
          0: lim = '0;
          1: lim = 24'd1;
          2: lim = CFG_W'($urandom_range(2, 40));
          3: lim = COUNT_MAX;
          default: lim = CFG_W'($urandom_range(0, 16777215));
        endcase
        set_limit(lim);
      end else begin
        // let the block run dry before carrying on
        drain();
      end
    end

    drain();
    repeat (8) @(posedge clk);
    $display("covered %0d items: %0d sessions (%0d reads), %0d ticks, %0d limit settings",
             n_items, n_sessions, n_reads, n_ticks, n_limits);
    $display("%0d distinct bytes given a value by loads or writes", known_list.size());
    if (n_fail == 0) begin
      $display("serial_backup_memory_slave_core regression: pass");
    end else begin
      $display("serial_backup_memory_slave_core regression: fail");
    end
    $finish;
  end

  // stop a hung run
  initial begin
    #4000000;
    $display("serial_backup_memory_slave_core regression: fail");
    $finish;
  end

endmodule
